// ===== rtl/rcfs_pkg.sv =====
// rcfs_pkg: widths, codes, colour tables and state type for the rgb colour fade sequencer
// no dependencies; imported by rcfs_divider, rgb_color_fade_sequencer_unit and the testbench
`default_nettype none

package rcfs_pkg;

   localparam int LEVEL_W   = 8;
   localparam int SPAN_W    = 16;
   localparam int SLOT_W    = 3;
   localparam int MODE_W    = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int CNT_W     = $clog2(SPAN_W);
   localparam int RSP_W     = 32;
   localparam int REQ_W     = 8;

   localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd6;

   localparam logic [SPAN_W-1:0] FADE_SPAN_RESET   = 16'd5300;
   localparam logic [SPAN_W-1:0] PAUSE_TICKS_RESET = 16'd1000;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FADE_SPAN   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PAUSE_TICKS = 1'd1;

   // request kinds
   localparam logic REQ_TICK     = 1'b0;
   localparam logic REQ_SET_MODE = 1'b1;

   // lamp modes
   localparam logic [MODE_W-1:0] MODE_BLACK        = 8'd0;
   localparam logic [MODE_W-1:0] MODE_CYCLE        = 8'd1;
   localparam logic [MODE_W-1:0] MODE_PRESET_FIRST = 8'd3;
   localparam logic [MODE_W-1:0] MODE_PRESET_LAST  = 8'd8;

   // element 0 red, 1 green, 2 blue
   typedef logic [2:0][LEVEL_W-1:0] rgb_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic rgb_type mk_rgb(input logic [LEVEL_W-1:0] r,
                                      input logic [LEVEL_W-1:0] g,
                                      input logic [LEVEL_W-1:0] b);
      rgb_type v;
      v[0] = r;
      v[1] = g;
      v[2] = b;
      return v;
   endfunction

   function automatic rgb_type cycle_rgb(input logic [SLOT_W-1:0] slot);
      rgb_type v;
      case (slot)
         3'd0:    v = mk_rgb(8'd255, 8'd0,   8'd0);
         3'd1:    v = mk_rgb(8'd255, 8'd255, 8'd0);
         3'd2:    v = mk_rgb(8'd0,   8'd255, 8'd0);
         3'd3:    v = mk_rgb(8'd0,   8'd255, 8'd255);
         3'd4:    v = mk_rgb(8'd0,   8'd0,   8'd255);
         3'd5:    v = mk_rgb(8'd255, 8'd0,   8'd255);
         3'd6:    v = mk_rgb(8'd255, 8'd255, 8'd255);
         default: v = mk_rgb(8'd255, 8'd0,   8'd0);
      endcase
      return v;
   endfunction

   // index is mode minus the first preset mode
   function automatic rgb_type preset_rgb(input logic [2:0] idx);
      rgb_type v;
      case (idx)
         3'd0:    v = mk_rgb(8'd0,   8'd255, 8'd0);
         3'd1:    v = mk_rgb(8'd0,   8'd0,   8'd255);
         3'd2:    v = mk_rgb(8'd255, 8'd0,   8'd0);
         3'd3:    v = mk_rgb(8'd255, 8'd255, 8'd0);
         3'd4:    v = mk_rgb(8'd170, 8'd170, 8'd255);
         3'd5:    v = mk_rgb(8'd255, 8'd255, 8'd255);
         default: v = mk_rgb(8'd0,   8'd0,   8'd0);
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rcfs_divider.sv =====
// rcfs_divider: bit-serial restoring divider, 16-bit dividend by 8-bit divisor
// one quotient bit per step; depends on rcfs_pkg
`default_nettype none

module rcfs_divider (
   input  wire logic                        clock,
   input  wire logic                        start,
   input  wire logic                        step,
   input  wire logic [rcfs_pkg::SPAN_W-1:0]  dividend,
   input  wire logic [rcfs_pkg::LEVEL_W-1:0] divisor,
   output logic      [rcfs_pkg::SPAN_W-1:0]  quotient
);
   import rcfs_pkg::*;

   logic [SPAN_W-1:0]  num_ff, num_in;
   logic [LEVEL_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0] den_ff, den_in;
   logic [LEVEL_W:0]   trial;
   logic [LEVEL_W:0]   diff;
   logic               ge;

   assign trial = {rem_ff, num_ff[SPAN_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   // dividend shifts out at the top while quotient bits shift in at the bottom
   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (step) begin
         rem_in = ge ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
         num_in = {num_ff[SPAN_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // zero difference means a zero interval
   assign quotient = (den_ff == '0) ? '0 : num_ff;

endmodule

`default_nettype wire

// ===== rtl/rgb_color_fade_sequencer_unit.sv =====
// rgb_color_fade_sequencer_unit: top level of the rgb lamp fade sequencer
// depends on rcfs_pkg and rcfs_divider
//
// Each request (a millisecond tick or a mode change) yields exactly one response carrying
// the lamp levels, the fading flag and the current cycle slot. When a pause ends and a
// new fade begins, a tick passes the divide and load states before the done state: the
// three step intervals are worked out by three bit-serial dividers running side by side,
// one quotient bit per cycle, then loaded. One request is in flight at a time; a new one
// is taken while the previous response still waits. Others go straight to the done state.
`default_nettype none

module rgb_color_fade_sequencer_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [rcfs_pkg::REQ_W-1:0]      req_tdata,  // [7:0] mode
   input  wire logic                           req_tuser,  // [0] req_type
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [24] fading, [27:25] target_index, rest zero
   output logic      [rcfs_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [rcfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [rcfs_pkg::SPAN_W-1:0]     csr_wdata
);
   import rcfs_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [SPAN_W-1:0] span_ff, pause_ticks_ff;

   rgb_type                  lamp_ff, lamp_in;
   rgb_type                  fade_ff, fade_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [2:0]               chan_busy_ff, chan_busy_in;
   logic [2:0][SPAN_W-1:0]   chan_wait_ff, chan_wait_in;
   logic [2:0][SPAN_W-1:0]   chan_int_ff, chan_int_in;
   logic                     pause_busy_ff, pause_busy_in;
   logic [SPAN_W-1:0]        pause_wait_ff, pause_wait_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   // tick outcome
   rgb_type                  tick_fade, tick_lamp;
   logic [2:0]               tick_busy;
   logic [2:0][SPAN_W-1:0]   tick_wait;
   logic                     tick_pause_busy;
   logic [SPAN_W-1:0]        tick_pause_wait;
   logic [SLOT_W-1:0]        tick_slot;
   logic                     tick_div_go;
   logic [2:0][LEVEL_W-1:0]  tick_divisor;

   logic [2:0][SPAN_W-1:0]   quot;
   logic                     accept;
   logic                     div_start;
   logic [MODE_W-1:0]        preset_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign div_start  = accept && (req_tuser == REQ_TICK) && tick_div_go;
   assign preset_off = req_tdata - MODE_PRESET_FIRST;

   // one tick: channel timers red, green, blue, then the pause timer if it was running
   always_comb begin
      rgb_type    tgt;
      rgb_type    ntgt;
      logic [2:0] clr;
      logic       stepped;
      tgt             = cycle_rgb(slot_ff);
      clr             = '0;
      stepped         = 1'b0;
      tick_fade       = fade_ff;
      tick_wait       = chan_wait_ff;
      tick_pause_busy = pause_busy_ff;
      tick_pause_wait = pause_wait_ff;
      tick_slot       = slot_ff;
      tick_div_go     = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (chan_busy_ff[c]) begin
            if (chan_wait_ff[c] <= SPAN_W'(1)) begin
               tick_wait[c] = '0;
               if (fade_ff[c] == tgt[c]) begin
                  clr[c] = 1'b1;
               end else begin
                  stepped      = 1'b1;
                  tick_fade[c] = (fade_ff[c] > tgt[c]) ? fade_ff[c] - 8'd1 : fade_ff[c] + 8'd1;
                  tick_wait[c] = chan_int_ff[c];
               end
            end else begin
               tick_wait[c] = chan_wait_ff[c] - SPAN_W'(1);
            end
         end
      end
      tick_busy = chan_busy_ff & ~clr;
      tick_lamp = stepped ? tick_fade : lamp_ff;
      if ((clr != '0) && (tick_busy == '0)) begin
         tick_pause_busy = 1'b1;
         tick_pause_wait = pause_ticks_ff;
      end
      if (pause_busy_ff) begin
         if (tick_pause_wait <= SPAN_W'(1)) begin
            tick_pause_wait = '0;
            tick_pause_busy = 1'b0;
            tick_div_go     = 1'b1;
            tick_slot       = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 3'd1;
         end else begin
            tick_pause_wait = tick_pause_wait - SPAN_W'(1);
         end
      end
      ntgt = cycle_rgb(tick_slot);
      for (int c = 0; c < 3; c++) begin
         tick_divisor[c] = (tick_fade[c] > ntgt[c]) ? tick_fade[c] - ntgt[c]
                                                    : ntgt[c] - tick_fade[c];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rcfs_divider u_div (
         .clock    (clock),
         .start    (div_start),
         .step     (state_ff == ST_DIV),
         .dividend (span_ff),
         .divisor  (tick_divisor[g]),
         .quotient (quot[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      lamp_in       = lamp_ff;
      fade_in       = fade_ff;
      slot_in       = slot_ff;
      chan_busy_in  = chan_busy_ff;
      chan_wait_in  = chan_wait_ff;
      chan_int_in   = chan_int_ff;
      pause_busy_in = pause_busy_ff;
      pause_wait_in = pause_wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_SET_MODE) begin
                  // every mode stops all timers first
                  chan_busy_in  = '0;
                  chan_wait_in  = '0;
                  pause_busy_in = 1'b0;
                  pause_wait_in = '0;
                  slot_in       = '0;
                  if (req_tdata == MODE_BLACK) begin
                     lamp_in = '0;
                  end else if (req_tdata == MODE_CYCLE) begin
                     fade_in       = cycle_rgb('0);
                     lamp_in       = cycle_rgb('0);
                     pause_busy_in = 1'b1;
                     pause_wait_in = pause_ticks_ff;
                  end else if (req_tdata >= MODE_PRESET_FIRST &&
                               req_tdata <= MODE_PRESET_LAST) begin
                     lamp_in = preset_rgb(preset_off[2:0]);
                  end
                  state_in = ST_DONE;
               end else begin
                  lamp_in       = tick_lamp;
                  fade_in       = tick_fade;
                  slot_in       = tick_slot;
                  chan_busy_in  = tick_busy;
                  chan_wait_in  = tick_wait;
                  pause_busy_in = tick_pause_busy;
                  pause_wait_in = tick_pause_wait;
                  if (tick_div_go) begin
                     cnt_in   = CNT_W'(SPAN_W - 1);
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            chan_int_in  = quot;
            chan_wait_in = quot;
            chan_busy_in = 3'b111;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, slot_ff, (chan_busy_ff != '0),
                               lamp_ff[2], lamp_ff[1], lamp_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         span_ff        <= FADE_SPAN_RESET;
         pause_ticks_ff <= PAUSE_TICKS_RESET;
         lamp_ff        <= '0;
         fade_ff        <= '0;
         slot_ff        <= '0;
         chan_busy_ff   <= '0;
         chan_wait_ff   <= '0;
         chan_int_ff    <= '0;
         pause_busy_ff  <= 1'b0;
         pause_wait_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         lamp_ff       <= lamp_in;
         fade_ff       <= fade_in;
         slot_ff       <= slot_in;
         chan_busy_ff  <= chan_busy_in;
         chan_wait_ff  <= chan_wait_in;
         chan_int_ff   <= chan_int_in;
         pause_busy_ff <= pause_busy_in;
         pause_wait_ff <= pause_wait_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && csr_addr == REG_FADE_SPAN) begin
            span_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == REG_PAUSE_TICKS) begin
            pause_ticks_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("cycle slot out of range");

   a_pause_excl : assert property (@(posedge clock) disable iff (reset)
      !(pause_busy_ff && (chan_busy_ff != '0)))
      else $error("pause running while a channel still fades");

   a_load_starts : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (chan_busy_ff == 3'b111) && !pause_busy_ff)
      else $error("fade did not start after interval load");

   a_div_len : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == '0) |=> (state_ff == ST_LOAD))
      else $error("divide phase did not end after its last step");

endmodule

`default_nettype wire

// ===== tb/tb_rgb_color_fade_sequencer_unit.sv =====
// testbench for the rgb colour fade sequencer: drives ticks and mode changes, predicts
// the lamp levels, fading flag and cycle slot, and checks every response against them
// depends on rcfs_pkg and rgb_color_fade_sequencer_unit
`default_nettype none

module tb_rgb_color_fade_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 25;

   typedef struct packed {
      logic              kind;
      logic [MODE_W-1:0] mode;
   } lamp_req_type;

   // response word, lowest bits last in the list
   typedef struct packed {
      logic [3:0]         pad;
      logic [SLOT_W-1:0]  slot;
      logic               fading;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
   } lamp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;   // [7:0] mode
   logic                  req_tuser = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] red, [15:8] green, [23:16] blue, [24] fading, [27:25] target_index
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [SPAN_W-1:0]     csr_wdata = '0;

   rgb_color_fade_sequencer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // lamp model state
   logic [SPAN_W-1:0]  span_q;
   logic [SPAN_W-1:0]  pause_q;
   rgb_type            lamp;
   rgb_type            fade;
   logic [SLOT_W-1:0]  slot;
   logic [2:0]         chan_busy;
   logic [SPAN_W-1:0]  chan_wait [3];
   logic [SPAN_W-1:0]  chan_ivl [3];
   logic               pause_on;
   logic [SPAN_W-1:0]  pause_left;

   lamp_req_type  pending_reqs [$];
   lamp_word_type lamp_expected [$];
   lamp_req_type  drv_item;
   lamp_word_type got_word;
   lamp_word_type want_word;

   int gap_left;
   int calm_req;
   int stall_left;
   int calm_rsp;
   int idle_cycles;
   int n_reqs;
   int n_modes;
   int n_rsps;
   int n_fades;
   int n_wraps;
   int n_settings;
   int n_mismatch;

   function automatic logic [LEVEL_W-1:0] cycle_level(input logic [SLOT_W-1:0] s,
                                                      input int ch);
      logic [23:0] bgr;
      case (s)
         3'd1:    bgr = {8'd0,   8'd255, 8'd255};
         3'd2:    bgr = {8'd0,   8'd255, 8'd0};
         3'd3:    bgr = {8'd255, 8'd255, 8'd0};
         3'd4:    bgr = {8'd255, 8'd0,   8'd0};
         3'd5:    bgr = {8'd255, 8'd0,   8'd255};
         3'd6:    bgr = {8'd255, 8'd255, 8'd255};
         default: bgr = {8'd0,   8'd0,   8'd255};
      endcase
      return bgr[ch*8 +: 8];
   endfunction

   function automatic logic [LEVEL_W-1:0] preset_level(input logic [MODE_W-1:0] idx,
                                                       input int ch);
      logic [23:0] bgr;
      case (idx)
         8'd0:    bgr = {8'd0,   8'd255, 8'd0};
         8'd1:    bgr = {8'd255, 8'd0,   8'd0};
         8'd2:    bgr = {8'd0,   8'd0,   8'd255};
         8'd3:    bgr = {8'd0,   8'd255, 8'd255};
         8'd4:    bgr = {8'd255, 8'd170, 8'd170};
         default: bgr = {8'd255, 8'd255, 8'd255};
      endcase
      return bgr[ch*8 +: 8];
   endfunction

   task automatic fade_start();
      logic [LEVEL_W-1:0] goal;
      logic [LEVEL_W-1:0] diff;
      if (slot == SLOT_LAST) begin
         slot = '0;
         n_wraps++;
      end else begin
         slot = slot + 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
         goal = cycle_level(slot, c);
         diff = (fade[c] > goal) ? fade[c] - goal : goal - fade[c];
         chan_ivl[c] = (diff == 0) ? '0 : span_q / diff;
         chan_wait[c] = chan_ivl[c];
      end
      chan_busy = 3'b111;
      n_fades++;
   endtask

   task automatic channel_step(input int c);
      logic [LEVEL_W-1:0] goal;
      goal = cycle_level(slot, c);
      if (fade[c] == goal) begin
         chan_busy[c] = 1'b0;
         if (chan_busy == 3'b000) begin
            pause_on = 1'b1;
            pause_left = pause_q;
         end
      end else begin
         if (fade[c] > goal)
            fade[c] = fade[c] - 1'b1;
         else
            fade[c] = fade[c] + 1'b1;
         lamp = fade;
         chan_wait[c] = chan_ivl[c];
      end
   endtask

   task automatic lamp_tick();
      logic       pause_was;
      logic [2:0] busy_was;
      pause_was = pause_on;
      busy_was = chan_busy;
      for (int c = 0; c < 3; c++) begin
         if (busy_was[c]) begin
            if (chan_wait[c] <= 1) begin
               chan_wait[c] = '0;
               channel_step(c);
            end else begin
               chan_wait[c] = chan_wait[c] - 1'b1;
            end
         end
      end
      // a pause begun on this tick does not count it
      if (pause_was && pause_on) begin
         if (pause_left <= 1) begin
            pause_left = '0;
            pause_on = 1'b0;
            fade_start();
         end else begin
            pause_left = pause_left - 1'b1;
         end
      end
   endtask

   task automatic lamp_set_mode(input logic [MODE_W-1:0] m);
      chan_busy = '0;
      pause_on = 1'b0;
      for (int c = 0; c < 3; c++)
         chan_wait[c] = '0;
      pause_left = '0;
      slot = '0;
      if (m == MODE_BLACK) begin
         lamp = '0;
      end else if (m == MODE_CYCLE) begin
         for (int c = 0; c < 3; c++)
            fade[c] = cycle_level('0, c);
         lamp = fade;
         pause_on = 1'b1;
         pause_left = pause_q;
      end else if (m >= MODE_PRESET_FIRST && m <= MODE_PRESET_LAST) begin
         for (int c = 0; c < 3; c++)
            lamp[c] = preset_level(m - MODE_PRESET_FIRST, c);
      end
      n_modes++;
   endtask

   function automatic lamp_word_type lamp_word();
      lamp_word_type w;
      w.pad = '0;
      w.slot = slot;
      w.fading = |chan_busy;
      w.blue = lamp[2];
      w.green = lamp[1];
      w.red = lamp[0];
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [LEVEL_W-1:0] want,
                                       input logic [LEVEL_W-1:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         n_mismatch++;
      end
   endfunction

   function automatic void push_req(input logic kind, input logic [MODE_W-1:0] m);
      lamp_req_type r;
      r.kind = kind;
      r.mode = m;
      pending_reqs.push_back(r);
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         calm_req = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (drv_item.kind == REQ_SET_MODE)
               lamp_set_mode(drv_item.mode);
            else
               lamp_tick();
            lamp_expected.push_back(lamp_word());
            n_reqs++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               drv_item = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= drv_item.mode;
               req_tuser <= drv_item.kind;
               if (calm_req == 0 && $urandom_range(0, 15) == 0)
                  calm_req = $urandom_range(20, 80);
               if (calm_req != 0) begin
                  calm_req--;
                  gap_left = 0;
               end else begin
                  gap_left = $urandom_range(0, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         calm_rsp = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_word = rsp_tdata;
            n_rsps++;
            if (lamp_expected.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, got %h",
                        $time, got_word);
               n_mismatch++;
            end else begin
               want_word = lamp_expected.pop_front();
               check_field("red", want_word.red, got_word.red);
               check_field("green", want_word.green, got_word.green);
               check_field("blue", want_word.blue, got_word.blue);
               check_field("fading", LEVEL_W'(want_word.fading), LEVEL_W'(got_word.fading));
               check_field("target_index", LEVEL_W'(want_word.slot), LEVEL_W'(got_word.slot));
               check_field("padding", LEVEL_W'(want_word.pad), LEVEL_W'(got_word.pad));
            end
            if (calm_rsp == 0 && $urandom_range(0, 15) == 0)
               calm_rsp = $urandom_range(20, 80);
            if (calm_rsp != 0) begin
               calm_rsp--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 7);
            end
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("rgb_color_fade_sequencer_unit test failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || lamp_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [SPAN_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FADE_SPAN)
         span_q = val;
      else
         pause_q = val;
   endtask

   task automatic set_timing(input logic [SPAN_W-1:0] span, input logic [SPAN_W-1:0] pause);
      wait_drained();
      write_csr(REG_FADE_SPAN, span);
      write_csr(REG_PAUSE_TICKS, pause);
      n_settings++;
      @(negedge clock);
   endtask

   // mostly a cycle start followed by a run of ticks, the rest random modes with shorter runs
   task automatic push_mixed(input int count);
      int n;
      int k;
      int run;
      n = 0;
      while (n < count) begin
         k = $urandom_range(0, 9);
         if (k < 6) begin
            push_req(REQ_SET_MODE, MODE_CYCLE);
            run = $urandom_range(5, 150);
         end else if (k < 9) begin
            push_req(REQ_SET_MODE, MODE_W'($urandom_range(0, 9)));
            run = $urandom_range(0, 10);
         end else begin
            push_req(REQ_SET_MODE, MODE_W'($urandom_range(0, 255)));
            run = $urandom_range(0, 10);
         end
         n++;
         repeat (run) begin
            push_req(REQ_TICK, MODE_W'($urandom_range(0, 255)));
            n++;
         end
      end
   endtask

   initial begin
      span_q = FADE_SPAN_RESET;
      pause_q = PAUSE_TICKS_RESET;
      lamp = '0;
      fade = '0;
      slot = '0;
      chan_busy = '0;
      for (int c = 0; c < 3; c++) begin
         chan_wait[c] = '0;
         chan_ivl[c] = '0;
      end
      pause_on = 1'b0;
      pause_left = '0;
      idle_cycles = 0;
      n_reqs = 0;
      n_modes = 0;
      n_rsps = 0;
      n_fades = 0;
      n_wraps = 0;
      n_settings = 0;
      n_mismatch = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every defined mode plus undefined ones at the reset timing, ticks in between
      push_req(REQ_TICK, 8'h00);
      push_req(REQ_SET_MODE, MODE_BLACK);
      push_req(REQ_TICK, 8'hff);
      push_req(REQ_SET_MODE, MODE_CYCLE);
      push_req(REQ_TICK, MODE_CYCLE);
      push_req(REQ_TICK, 8'h55);
      push_req(REQ_SET_MODE, 8'd2);
      push_req(REQ_TICK, 8'haa);
      for (int m = MODE_PRESET_FIRST; m <= MODE_PRESET_LAST; m++) begin
         push_req(REQ_SET_MODE, MODE_W'(m));
         push_req(REQ_TICK, 8'h00);
      end
      push_req(REQ_SET_MODE, 8'd9);
      push_req(REQ_SET_MODE, 8'd255);
      push_req(REQ_SET_MODE, 8'd128);
      push_req(REQ_SET_MODE, MODE_BLACK);
      push_req(REQ_SET_MODE, MODE_CYCLE);

      // zero span and zero pause: step every tick through the first fades
      set_timing(16'd0, 16'd0);
      push_req(REQ_SET_MODE, MODE_CYCLE);
      repeat (500) push_req(REQ_TICK, MODE_W'($urandom_range(0, 255)));

      set_timing(16'hffff, 16'hffff);
      push_mixed(60);

      set_timing(16'd1, 16'd2);
      push_mixed(200);

      set_timing(SPAN_W'($urandom_range(100, 1500)), SPAN_W'($urandom_range(0, 20)));
      push_mixed(200);

      set_timing(SPAN_W'($urandom_range(0, 65535)), SPAN_W'($urandom_range(0, 5)));
      push_mixed(100);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d mode changes) under %0d timing settings",
               n_reqs, n_modes, n_settings + 1);
      $display("%0d responses checked, %0d fades started, %0d cycle wraps, %0d mismatches",
               n_rsps, n_fades, n_wraps, n_mismatch);
      if (n_mismatch == 0)
         $display("rgb_color_fade_sequencer_unit test passed");
      else
         $display("rgb_color_fade_sequencer_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
